// ----- hdl/bswlc_pkg.sv -----
// Package for the byte stream word and line counter: default widths,
// operation and register codes, and the byte classification function.
// Depends on nothing; imported by byte_stream_word_line_counter_unit.
package bswlc_pkg;

    localparam int COUNT_WIDTH_DEF       = 32;
    localparam int LINE_LENGTH_WIDTH_DEF = 8;
    localparam int BYTE_WIDTH            = 8;
    localparam int OP_WIDTH              = 2;
    localparam int CFG_INDEX_WIDTH       = 1;

    localparam logic [BYTE_WIDTH-1:0] LINE_END_RESET = 8'd13;
    localparam logic [BYTE_WIDTH-1:0] SKIP_RESET     = 8'd10;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_DATA  = 2'd0,
        OP_EOF   = 2'd1,
        OP_TOTAL = 2'd2
    } t_op;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LINE_END = 1'd0,
        REG_SKIP     = 1'd1
    } t_reg;

    // Whitespace as the C library sees it: tab, newline, vertical tab,
    // form feed, carriage return and space.
    function automatic logic is_space(input logic [BYTE_WIDTH-1:0] b);
        return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
    endfunction

endpackage

// ----- hdl/byte_stream_word_line_counter_unit.sv -----
// Top level of the byte stream word and line counter.
// Depends on bswlc_pkg for widths, operation codes and the space test.
//
// The block counts bytes, words and lines of a file that arrives one byte
// per beat, and keeps the longest terminated line. Each slave beat carries
// an operation in tuser: a data byte, an end of file, or a totals request.
// A data byte yields no output beat; an end of file yields one beat with
// the file counts (tuser is 0), folds them into the running totals and
// clears the file state; a totals request yields one beat with the totals
// (tuser is 1). Unused operation code 3 is dropped. Throughput is one beat
// per clock unless the slave side stalls: a beat is taken into an input
// register, and from there one pass of increment, add and compare logic
// updates the counters and, for a report, loads the output register. The
// slave side stalls only when a report sits in the input register while
// the output register holds an untaken beat. Configuration registers (line
// end byte, skip byte) may be written at any time the stream is idle; the
// write port is always ready.
module byte_stream_word_line_counter_unit #(
    parameter int COUNT_WIDTH       = bswlc_pkg::COUNT_WIDTH_DEF,
    parameter int LINE_LENGTH_WIDTH = bswlc_pkg::LINE_LENGTH_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration write channel.
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bswlc_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [bswlc_pkg::BYTE_WIDTH-1:0]        i_cfg_data,
    // Slave stream.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: data_byte [7:0]
    input  logic [bswlc_pkg::BYTE_WIDTH-1:0]        s_axis_tdata,
    // tuser: operation [1:0]
    input  logic [bswlc_pkg::OP_WIDTH-1:0]          s_axis_tuser,
    // Master stream.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata from bit 0 up: line_count, word_count, byte_count, longest_line,
    // then zero fill to a whole byte.
    output logic [8*((3*COUNT_WIDTH+LINE_LENGTH_WIDTH+7)/8)-1:0] m_axis_tdata,
    // tuser: is_total [0]
    output logic                                    m_axis_tuser
);
    import bswlc_pkg::*;

    localparam int CW       = COUNT_WIDTH;
    localparam int LW       = LINE_LENGTH_WIDTH;
    localparam int OUT_BITS = 3*CW + LW;
    localparam int OUT_W    = 8*((OUT_BITS+7)/8);

    // Configuration registers.
    logic [BYTE_WIDTH-1:0] r_line_end;
    logic [BYTE_WIDTH-1:0] r_skip;

    // Input register.
    logic                  r_in_valid;
    t_op                   r_in_op;
    logic [BYTE_WIDTH-1:0] r_in_byte;

    // Counter state.
    logic [CW-1:0] r_file_lines, r_file_words, r_file_bytes;
    logic [LW-1:0] r_file_longest, r_cur_len;
    logic          r_after_space;
    logic [CW-1:0] r_tot_lines, r_tot_words, r_tot_bytes;
    logic [LW-1:0] r_tot_longest;

    // Output register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_total;

    logic             in_report;
    logic             out_free;
    logic             advance;
    logic             sp;
    logic             is_line_end;
    logic [OUT_W-1:0] n_out_data;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_total;

    // The input register moves on unless it holds a report that cannot yet
    // enter a busy output register.
    assign in_report     = (r_in_op == OP_EOF) || (r_in_op == OP_TOTAL);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!in_report || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    assign sp          = is_space(r_in_byte);
    assign is_line_end = (r_in_byte == r_line_end);

    always_comb begin
        n_out_data = '0;
        if (r_in_op == OP_TOTAL) begin
            n_out_data[OUT_BITS-1:0] = {r_tot_longest, r_tot_bytes, r_tot_words, r_tot_lines};
        end else begin
            n_out_data[OUT_BITS-1:0] = {r_file_longest, r_file_bytes, r_file_words,
                                        r_file_lines};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_end <= LINE_END_RESET;
            r_skip     <= SKIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_LINE_END: r_line_end <= i_cfg_data;
                REG_SKIP:     r_skip     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && in_report) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && in_report) begin
            r_out_data  <= n_out_data;
            r_out_total <= (r_in_op == OP_TOTAL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_lines   <= '0;
            r_file_words   <= '0;
            r_file_bytes   <= '0;
            r_file_longest <= '0;
            r_cur_len      <= '0;
            r_after_space  <= 1'b1;
            r_tot_lines    <= '0;
            r_tot_words    <= '0;
            r_tot_bytes    <= '0;
            r_tot_longest  <= '0;
        end else if (advance) begin
            unique case (r_in_op)
                OP_DATA: begin
                    r_file_bytes  <= r_file_bytes + CW'(1);
                    if (r_after_space && !sp) begin
                        r_file_words <= r_file_words + CW'(1);
                    end
                    r_after_space <= sp;
                    // A line end wins over the skip byte when both match.
                    if (is_line_end) begin
                        r_file_lines <= r_file_lines + CW'(1);
                        if (r_cur_len > r_file_longest) begin
                            r_file_longest <= r_cur_len;
                        end
                        r_cur_len <= '0;
                    end else if ((r_cur_len != '0) || (r_in_byte != r_skip)) begin
                        r_cur_len <= r_cur_len + LW'(1);
                    end
                end
                OP_EOF: begin
                    r_tot_lines <= r_tot_lines + r_file_lines;
                    r_tot_words <= r_tot_words + r_file_words;
                    r_tot_bytes <= r_tot_bytes + r_file_bytes;
                    if (r_file_longest > r_tot_longest) begin
                        r_tot_longest <= r_file_longest;
                    end
                    r_file_lines   <= '0;
                    r_file_words   <= '0;
                    r_file_bytes   <= '0;
                    r_file_longest <= '0;
                    r_cur_len      <= '0;
                    r_after_space  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // An end of file leaves the file state cleared.
    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_EOF) |=>
            (r_file_bytes == '0 && r_file_lines == '0 && r_after_space))
        else $error("file state not cleared after end of file");

    // A result appears only from a report leaving the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && in_report))
        else $error("output beat without a report");

    // A line end byte always restarts the line length.
    a_line_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_DATA && is_line_end) |=> (r_cur_len == '0))
        else $error("line length not cleared at line end");

    // A blocked report must hold off the slave side.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && in_report && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("slave side ready while a report is blocked");

endmodule
